/* rtl/sbrd_pkg.sv */
// Shared types and constants for the SBUS ring buffer deframer.
// Used by sbrd_cfg, sbrd_ctrl, sbrd_datapath and the top level.
package sbrd_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
  localparam int BYTE_W    = 8;

  localparam int FRAME_LEN   = 25;
  localparam int FR_CNT_W    = $clog2(FRAME_LEN);
  localparam int FR_PAY_LAST = 22;   // bytes 1..22 carry the channel bits
  localparam int FR_FLAG_IDX = 23;
  localparam int FR_LAST_IDX = FRAME_LEN - 1;

  localparam int NUM_CHAN  = 16;
  localparam int CHAN_W    = 11;
  localparam int CH_IDX_W  = $clog2(NUM_CHAN);
  localparam int PAYLOAD_W = NUM_CHAN * CHAN_W;
  localparam int CNT_W     = 16;

  localparam logic [BYTE_W-1:0] LOST_FLAG   = 8'h0C;
  localparam logic [CHAN_W-1:0] CHAN_CENTER = 11'h400;

  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'd15;
  localparam logic [BYTE_W-1:0] TRAILER_RST = 8'd0;

  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 3;
  localparam int IN_USER_W  = 2;
  localparam int IN_DATA_W  = 8;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PARSE = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_NOFRAME = 3'd4;

  // register indexes
  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_TRAILER = 1'b1;

  typedef struct packed {
    logic       load_in;
    logic       set_status;
    logic [2:0] status;
    logic       wr_byte;
    logic       set_ovf;
    logic       rd_take;
    logic       clr_buf;
    logic       skip_found;
    logic       skip_all;
    logic       scan_inc;
    logic       fr_take;
    logic       ch_load;
    logic       one_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fill_zero;
    logic       fill_full;
    logic       fill_short;
    logic       scan_end;
    logic       match;
    logic       fr_last;
    logic       ch_last;
    logic       out_free;
  } stat_t;

endpackage

/* rtl/sbrd_cfg.sv */
// APB register block: frame header and trailer byte values.
// Depends on sbrd_pkg.
module sbrd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [sbrd_pkg::BYTE_W-1:0] header_o,
  output logic [sbrd_pkg::BYTE_W-1:0] trailer_o
);

  logic [sbrd_pkg::BYTE_W-1:0] header_q, trailer_q;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= sbrd_pkg::HEADER_RST;
      trailer_q <= sbrd_pkg::TRAILER_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        sbrd_pkg::REG_HEADER:  header_q  <= pwdata[sbrd_pkg::BYTE_W-1:0];
        sbrd_pkg::REG_TRAILER: trailer_q <= pwdata[sbrd_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      sbrd_pkg::REG_HEADER:  prdata = {24'd0, header_q};
      sbrd_pkg::REG_TRAILER: prdata = {24'd0, trailer_q};
      default:               prdata = '0;
    endcase
  end

  assign header_o  = header_q;
  assign trailer_o = trailer_q;

endmodule

/* rtl/sbrd_datapath.sv */
// Datapath: byte ring memory, pointers, fill level, counters, frame
// shift register and the output register. Depends on sbrd_pkg.
module sbrd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sbrd_pkg::cmd_t                  cmd_i,
  output sbrd_pkg::stat_t                 stat_o,
  input  logic [1:0]                      in_kind_i,
  input  logic [sbrd_pkg::BYTE_W-1:0]     in_data_i,
  input  logic [sbrd_pkg::BYTE_W-1:0]     header_i,
  input  logic [sbrd_pkg::BYTE_W-1:0]     trailer_i,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [sbrd_pkg::OUT_DATA_W-1:0] m_data_o,
  output logic [sbrd_pkg::OUT_USER_W-1:0] m_user_o,
  output logic                            m_last_o
);

  localparam int PW = sbrd_pkg::PTR_W;
  localparam int FW = sbrd_pkg::FILL_W;
  localparam int BW = sbrd_pkg::BYTE_W;

  logic [BW-1:0] mem_q [sbrd_pkg::BUF_DEPTH];
  logic [BW-1:0] rd_a_q, rd_b_q;
  logic [PW-1:0] addr_a, addr_b;

  logic [1:0]    kind_q;
  logic [BW-1:0] data_q;
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, scan_q, scan_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [sbrd_pkg::CNT_W-1:0] frames_q, frames_d, errors_q, errors_d;
  logic [2:0]    status_q;
  logic [BW-1:0] popped_q;
  logic [sbrd_pkg::FR_CNT_W-1:0] fr_cnt_q, fr_cnt_d;
  logic [sbrd_pkg::CH_IDX_W-1:0] ch_idx_q, ch_idx_d;
  logic [sbrd_pkg::PAYLOAD_W-1:0] payload_q, payload_d;
  logic          lost_q, lost_d;
  logic [FW-1:0] skip_n;

  logic          out_valid_q;
  logic          out_load;
  logic          out_last_q;
  logic [2:0]    out_status_q;
  logic [BW-1:0] out_popped_q;
  logic [sbrd_pkg::CH_IDX_W-1:0] out_idx_q;
  logic [sbrd_pkg::CHAN_W-1:0]   out_value_q;
  logic          out_lost_q;
  logic [FW-1:0] out_fill_q;
  logic          out_ovf_q;
  logic [sbrd_pkg::CNT_W-1:0] out_frames_q, out_errors_q;

  // candidate byte and the last byte of a frame starting there
  assign addr_a = rptr_q + scan_q;
  assign addr_b = rptr_q + scan_q + PW'(sbrd_pkg::FRAME_LEN - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      mem_q[wptr_q] <= data_q;
    end
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= in_kind_i;
      data_q <= in_data_i;
    end
  end

  assign skip_n = {1'b0, scan_q} + FW'(1);

  always_comb begin
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    scan_d    = scan_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    frames_d  = frames_q;
    errors_d  = errors_q;
    fr_cnt_d  = fr_cnt_q;
    ch_idx_d  = ch_idx_q;
    payload_d = payload_q;
    lost_d    = lost_q;
    if (cmd_i.clr_buf) begin
      wptr_d = '0;
      rptr_d = '0;
      fill_d = '0;
      ovf_d  = 1'b0;
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.wr_byte) begin
      wptr_d = wptr_q + PW'(1);
      fill_d = fill_q + FW'(1);
    end
    if (cmd_i.rd_take) begin
      rptr_d = rptr_q + PW'(1);
      fill_d = fill_q - FW'(1);
    end
    if (cmd_i.scan_inc) begin
      scan_d = scan_q + PW'(1);
    end
    if (cmd_i.skip_found) begin
      rptr_d   = rptr_q + scan_q;
      fill_d   = fill_q - {1'b0, scan_q};
      scan_d   = '0;
      fr_cnt_d = '0;
    end
    if (cmd_i.skip_all) begin
      rptr_d   = rptr_q + skip_n[PW-1:0];
      fill_d   = fill_q - skip_n;
      scan_d   = '0;
      errors_d = errors_q + sbrd_pkg::CNT_W'(1);
    end
    if (cmd_i.fr_take) begin
      rptr_d   = rptr_q + PW'(1);
      fill_d   = fill_q - FW'(1);
      fr_cnt_d = fr_cnt_q + sbrd_pkg::FR_CNT_W'(1);
      if (fr_cnt_q != '0 &&
          fr_cnt_q <= sbrd_pkg::FR_CNT_W'(sbrd_pkg::FR_PAY_LAST)) begin
        payload_d = {rd_a_q, payload_q[sbrd_pkg::PAYLOAD_W-1:BW]};
      end
      if (fr_cnt_q == sbrd_pkg::FR_CNT_W'(sbrd_pkg::FR_FLAG_IDX)) begin
        lost_d = (rd_a_q == sbrd_pkg::LOST_FLAG);
      end
      if (stat_o.fr_last) begin
        frames_d = frames_q + sbrd_pkg::CNT_W'(1);
        ch_idx_d = '0;
      end
    end
    if (cmd_i.ch_load) begin
      payload_d = payload_q >> sbrd_pkg::CHAN_W;
      ch_idx_d  = ch_idx_q + sbrd_pkg::CH_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      scan_q   <= '0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      frames_q <= '0;
      errors_q <= '0;
      fr_cnt_q <= '0;
      ch_idx_q <= '0;
    end else begin
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      scan_q   <= scan_d;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      frames_q <= frames_d;
      errors_q <= errors_d;
      fr_cnt_q <= fr_cnt_d;
      ch_idx_q <= ch_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    lost_q    <= lost_d;
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
      popped_q <= '0;
    end
    if (cmd_i.rd_take) begin
      popped_q <= rd_a_q;
    end
  end

  // output register
  assign out_load = cmd_i.ch_load | cmd_i.one_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fill_q   <= fill_q;
      out_ovf_q    <= ovf_q;
      out_frames_q <= frames_q;
      out_errors_q <= errors_q;
      if (cmd_i.ch_load) begin
        out_status_q <= sbrd_pkg::ST_DONE;
        out_popped_q <= '0;
        out_idx_q    <= ch_idx_q;
        out_value_q  <= payload_q[sbrd_pkg::CHAN_W-1:0] ^ sbrd_pkg::CHAN_CENTER;
        out_lost_q   <= lost_q;
        out_last_q   <= stat_o.ch_last;
      end else begin
        out_status_q <= status_q;
        out_popped_q <= popped_q;
        out_idx_q    <= '0;
        out_value_q  <= '0;
        out_lost_q   <= 1'b0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_status_q;
  assign m_data_o  = {6'd0, out_errors_q, out_frames_q, out_ovf_q, out_fill_q,
                      out_lost_q, out_value_q, out_idx_q, out_popped_q};

  assign stat_o.kind       = kind_q;
  assign stat_o.fill_zero  = (fill_q == '0);
  assign stat_o.fill_full  = (fill_q == FW'(sbrd_pkg::BUF_DEPTH));
  assign stat_o.fill_short = (fill_q < FW'(sbrd_pkg::FRAME_LEN));
  assign stat_o.scan_end   = ({1'b0, scan_q} == fill_q - FW'(sbrd_pkg::FRAME_LEN));
  assign stat_o.match      = (rd_a_q == header_i) && (rd_b_q == trailer_i);
  assign stat_o.fr_last    = (fr_cnt_q == sbrd_pkg::FR_CNT_W'(sbrd_pkg::FR_LAST_IDX));
  assign stat_o.ch_last    = (ch_idx_q == sbrd_pkg::CH_IDX_W'(sbrd_pkg::NUM_CHAN - 1));
  assign stat_o.out_free   = !out_valid_q || m_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(sbrd_pkg::BUF_DEPTH))
    else $error("fill level above buffer depth");

  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(wptr_q - rptr_q) == fill_q[PW-1:0])
    else $error("pointers disagree with fill level");

  a_midframe_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (out_status_q == sbrd_pkg::ST_DONE))
    else $error("non-final result without done status");

endmodule

/* rtl/sbrd_ctrl.sv */
// Controller state machine: sequences writes, reads, clears, the frame
// search, the frame fetch and result emission. Depends on sbrd_pkg.
module sbrd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  sbrd_pkg::stat_t stat_i,
  output sbrd_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_RD_TAKE   = 4'd2;
  localparam logic [3:0] S_SCAN_ADDR = 4'd3;
  localparam logic [3:0] S_SCAN_CMP  = 4'd4;
  localparam logic [3:0] S_FR_ADDR   = 4'd5;
  localparam logic [3:0] S_FR_TAKE   = 4'd6;
  localparam logic [3:0] S_EMIT_CH   = 4'd7;
  localparam logic [3:0] S_EMIT_ONE  = 4'd8;

  logic [3:0] state_q, state_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load_in = s_valid_i && s_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = sbrd_pkg::ST_DONE;
        state_d          = S_EMIT_ONE;
        unique case (stat_i.kind)
          sbrd_pkg::KIND_WRITE: begin
            if (stat_i.fill_full) begin
              cmd_o.set_ovf = 1'b1;
              cmd_o.status  = sbrd_pkg::ST_FULL;
            end else begin
              cmd_o.wr_byte = 1'b1;
            end
          end
          sbrd_pkg::KIND_READ: begin
            if (stat_i.fill_zero) begin
              cmd_o.status = sbrd_pkg::ST_EMPTY;
            end else begin
              state_d = S_RD_TAKE;
            end
          end
          sbrd_pkg::KIND_PARSE: begin
            if (stat_i.fill_short) begin
              cmd_o.status = sbrd_pkg::ST_SHORT;
            end else begin
              state_d = S_SCAN_ADDR;
            end
          end
          sbrd_pkg::KIND_CLEAR: begin
            cmd_o.clr_buf = 1'b1;
          end
          default: ;
        endcase
      end
      S_RD_TAKE: begin
        cmd_o.rd_take = 1'b1;
        state_d       = S_EMIT_ONE;
      end
      S_SCAN_ADDR: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.skip_found = 1'b1;
          state_d          = S_FR_ADDR;
        end else if (stat_i.scan_end) begin
          cmd_o.skip_all   = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = sbrd_pkg::ST_NOFRAME;
          state_d          = S_EMIT_ONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_SCAN_ADDR;
        end
      end
      S_FR_ADDR: begin
        state_d = S_FR_TAKE;
      end
      S_FR_TAKE: begin
        cmd_o.fr_take = 1'b1;
        state_d       = stat_i.fr_last ? S_EMIT_CH : S_FR_ADDR;
      end
      S_EMIT_CH: begin
        if (stat_i.out_free) begin
          cmd_o.ch_load = 1'b1;
          if (stat_i.ch_last) state_d = S_IDLE;
        end
      end
      S_EMIT_ONE: begin
        if (stat_i.out_free) begin
          cmd_o.one_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction not dispatched");

endmodule

/* rtl/sbus_ring_buffer_deframer.sv */
// Top level of the SBUS ring buffer deframer.
// Instantiates sbrd_cfg, sbrd_ctrl and sbrd_datapath; depends on sbrd_pkg.

// One input transaction is processed at a time; a new one is taken once the
// previous one has placed its last result in the output register, so results
// may still wait downstream. Write, clear, a read of an empty buffer and a
// parse with fewer than 25 bytes each give one result after dispatch; any other
// read first takes its byte from the ring. A parse with enough bytes checks
// frame-start candidates in turn (each candidate is one registered read of the
// 256-byte ring on two ports, then a compare), up to 232 candidates. A failed
// search gives one result with status 4 and leaves the last 24 bytes. A found
// frame fetches the 25 frame bytes one by one through the ring's read port,
// then gives one channel result per cycle (16) while the output side is ready,
// before the next transaction is taken. No clearing pass is needed after reset.
module sbus_ring_buffer_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] popped_byte, [11:8] channel_index, [22:12] channel_value,
  // [23] signal_lost, [32:24] fill_count, [33] overflow_seen,
  // [49:34] frames_decoded, [65:50] errors_seen, [71:66] zero
  output logic [71:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sbrd_pkg::cmd_t              cmd;
  sbrd_pkg::stat_t             stat;
  logic [sbrd_pkg::BYTE_W-1:0] header_val, trailer_val;

  sbrd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .header_o  (header_val),
    .trailer_o (trailer_val)
  );

  sbrd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sbrd_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_kind_i (s_axis_tuser_i),
    .in_data_i (s_axis_tdata_i),
    .header_i  (header_val),
    .trailer_i (trailer_val),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the SBUS ring buffer deframer.
// Needs sbrd_pkg and sbus_ring_buffer_deframer; directed table first, then random traffic.
module tb_top;
  import sbrd_pkg::*;

  localparam int          RAND_ITEMS  = 160;
  localparam int          QUIET_ITEMS = 30;
  localparam int          CFG_EVERY   = 40;
  localparam int          DRAIN_WAIT  = 600;
  // cycle cap for the whole run, sized from the slowest parse plus a fully stalled 16-result burst per item
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  popped;
    logic [3:0]  chan_idx;
    logic [10:0] chan_val;
    logic        lost;
    logic        last;
    logic [8:0]  fill;
    logic        ovf;
    logic [15:0] frames;
    logic [15:0] errs;
  } sbus_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FRAME, ROW_FILL} row_op_e;

  typedef struct packed {
    row_op_e    op;
    logic [1:0] kind;
    logic [7:0] data;     // item byte, or payload byte of a frame
    logic [7:0] flag;     // frame byte 23
    logic       good;     // frame ends in the trailer value
    logic [8:0] count;    // writes of a fill row
    logic       typed;    // status, popped byte and fill given below
    logic [2:0] status;
    logic [7:0] popped;
    logic [8:0] fill;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_ITEM,  KIND_READ,  8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_EMPTY,   8'h00, 9'd0},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_SHORT,   8'h00, 9'd0},
    '{ROW_ITEM,  KIND_WRITE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'h00, 9'd1},
    '{ROW_ITEM,  KIND_WRITE, 8'hFF, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'h00, 9'd2},
    '{ROW_ITEM,  KIND_READ,  8'hFF, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'h00, 9'd1},
    '{ROW_ITEM,  KIND_READ,  8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'hFF, 9'd0},
    '{ROW_ITEM,  KIND_WRITE, 8'hA5, 8'h00, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    // all channels at the top, signal lost
    '{ROW_FRAME, KIND_WRITE, 8'hFF, 8'h0C, 1'b1, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    // all channels at the bottom
    '{ROW_FRAME, KIND_WRITE, 8'h00, 8'h00, 1'b1, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    // wrong trailer: search fails and keeps the last 24 bytes
    '{ROW_FRAME, KIND_WRITE, 8'h5A, 8'h0D, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_NOFRAME, 8'h00, 9'd24},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_SHORT,   8'h00, 9'd24},
    '{ROW_ITEM,  KIND_CLEAR, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'h00, 9'd0},
    '{ROW_FILL,  KIND_WRITE, 8'h00, 8'h00, 1'b0, 9'd256, 1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_WRITE, 8'h3C, 8'h00, 1'b0, 9'd0,   1'b1, ST_FULL,    8'h00, 9'd256},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    // the search for this frame runs across the ring wrap
    '{ROW_FRAME, KIND_WRITE, 8'hC3, 8'h0C, 1'b1, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_PARSE, 8'h00, 8'h00, 1'b0, 9'd0,   1'b0, ST_DONE,    8'h00, 9'd0},
    '{ROW_ITEM,  KIND_CLEAR, 8'h00, 8'h00, 1'b0, 9'd0,   1'b1, ST_DONE,    8'h00, 9'd0}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser_i  = 2'b00;   // [1:0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] popped_byte, [11:8] channel_index, [22:12] channel_value, [23] signal_lost,
  // [32:24] fill_count, [33] overflow_seen, [49:34] frames_decoded, [65:50] errors_seen
  logic [71:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;            // [2:0] status
  logic        m_axis_tlast_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = 3'd0;
  logic [31:0] pwdata  = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  sbus_ring_buffer_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // shadow of the block state
  logic [7:0]        ring [BUF_DEPTH];
  logic [PTR_W-1:0]  wr_ptr     = '0;
  logic [PTR_W-1:0]  rd_ptr     = '0;
  logic [FILL_W-1:0] fill_lvl   = '0;
  logic              ovf_flag   = 1'b0;
  logic [15:0]       frames_cnt = '0;
  logic [15:0]       errs_cnt   = '0;
  logic [7:0]        hdr_val    = HEADER_RST;
  logic [7:0]        trl_val    = TRAILER_RST;

  sbus_result_t pending_results [$];
  sbus_result_t due, typed_res;
  dir_row_t     row;
  int unsigned  mismatch_cnt = 0;
  int unsigned  items_sent   = 0;
  int unsigned  cycle_cnt    = 0;
  int unsigned  rand_base, cfg_at, cfg_phase, pick;
  logic [7:0]   flag_byte;
  bit           quiet        = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void push_result(input logic [2:0] st, input logic [7:0] popped,
                                      input logic [3:0] idx, input logic [10:0] val,
                                      input logic lost, input logic last);
    sbus_result_t r;
    r = '{st, popped, idx, val, lost, last, fill_lvl, ovf_flag, frames_cnt, errs_cnt};
    pending_results.push_back(r);
  endfunction

  // Applies one accepted transaction to the shadow state and queues its results.
  function automatic void deframe_step(input logic [1:0] kind, input logic [7:0] din);
    logic [7:0]       frame [FRAME_LEN];
    logic [PTR_W-1:0] pos;
    int unsigned      span, skip, bitpos, at;
    bit               found;
    logic             lost;
    logic [23:0]      word;
    logic [10:0]      raw;
    case (kind)
      KIND_WRITE: begin
        if (fill_lvl >= BUF_DEPTH) begin
          ovf_flag = 1'b1;
          push_result(ST_FULL, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
        end else begin
          ring[wr_ptr] = din;
          wr_ptr = wr_ptr + 1'b1;
          fill_lvl = fill_lvl + 1'b1;
          push_result(ST_DONE, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
        end
      end
      KIND_READ: begin
        if (fill_lvl == 0) begin
          push_result(ST_EMPTY, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
        end else begin
          frame[0] = ring[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          fill_lvl = fill_lvl - 1'b1;
          push_result(ST_DONE, frame[0], 4'd0, 11'd0, 1'b0, 1'b1);
        end
      end
      KIND_CLEAR: begin
        wr_ptr   = '0;
        rd_ptr   = '0;
        fill_lvl = '0;
        ovf_flag = 1'b0;
        push_result(ST_DONE, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
      end
      default: begin
        if (fill_lvl < FRAME_LEN) begin
          push_result(ST_SHORT, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
        end else begin
          span  = fill_lvl - FRAME_LEN;
          found = 1'b0;
          skip  = span + 1;
          for (int i = 0; i <= span && !found; i++) begin
            pos = rd_ptr + PTR_W'(i);
            if (ring[pos] == hdr_val && ring[PTR_W'(pos + FR_LAST_IDX)] == trl_val) begin
              found = 1'b1;
              skip  = i;
            end
          end
          rd_ptr   = rd_ptr + PTR_W'(skip);
          fill_lvl = fill_lvl - FILL_W'(skip);
          if (!found) begin
            errs_cnt = errs_cnt + 1'b1;
            push_result(ST_NOFRAME, 8'h00, 4'd0, 11'd0, 1'b0, 1'b1);
          end else begin
            for (int j = 0; j < FRAME_LEN; j++) begin
              frame[j] = ring[rd_ptr];
              rd_ptr = rd_ptr + 1'b1;
            end
            fill_lvl   = fill_lvl - FILL_W'(FRAME_LEN);
            frames_cnt = frames_cnt + 1'b1;
            lost = (frame[FR_FLAG_IDX] == LOST_FLAG);
            // channels are packed LSB first from byte 1 on
            for (int k = 0; k < NUM_CHAN; k++) begin
              bitpos = CHAN_W * k;
              at     = 1 + bitpos / 8;
              word   = {frame[at+2], frame[at+1], frame[at]};
              raw    = 11'(word >> (bitpos % 8));
              push_result(ST_DONE, 8'h00, 4'(k), raw - CHAN_CENTER, lost, k == NUM_CHAN - 1);
            end
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual tdata %0h tuser %0h",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        mismatch_cnt++;
      end else begin
        due = pending_results.pop_front();
        check_field("status",         due.status,   m_axis_tuser_o);
        check_field("popped_byte",    due.popped,   m_axis_tdata_o[7:0]);
        check_field("channel_index",  due.chan_idx, m_axis_tdata_o[11:8]);
        check_field("channel_value",  due.chan_val, m_axis_tdata_o[22:12]);
        check_field("signal_lost",    due.lost,     m_axis_tdata_o[23]);
        check_field("last",           due.last,     m_axis_tlast_o);
        check_field("fill_count",     due.fill,     m_axis_tdata_o[32:24]);
        check_field("overflow_seen",  due.ovf,      m_axis_tdata_o[33]);
        check_field("frames_decoded", due.frames,   m_axis_tdata_o[49:34]);
        check_field("errors_seen",    due.errs,     m_axis_tdata_o[65:50]);
        check_field("tdata padding",  32'h0,        m_axis_tdata_o[71:66]);
      end
    end
  end

  // result side backpressure: random runs of ready and stalls, none once quiet
  int unsigned rdy_left  = 0;
  logic        rdy_state = 1'b1;
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      if (rdy_left == 0) begin
        rdy_state = ($urandom_range(0, 3) != 0);
        rdy_left  = $urandom_range(1, 16);
      end
      rdy_left--;
      m_axis_tready_i <= rdy_state;
    end
  end

  task automatic hold_off(input int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // tvalid stays high after the transaction; whoever drives next lowers or reuses it
  task automatic send_item(input logic [1:0] kind, input logic [7:0] din);
    if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 16));
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= din;
    do @(posedge clk_i); while (!s_axis_tready_o);
    deframe_step(kind, din);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] pay, input bit rand_pay, input logic [7:0] flag,
                            input bit good);
    send_item(KIND_WRITE, hdr_val);
    repeat (FR_PAY_LAST) send_item(KIND_WRITE, rand_pay ? 8'($urandom) : pay);
    send_item(KIND_WRITE, flag);
    send_item(KIND_WRITE, good ? trl_val : ~trl_val);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input logic idx, input logic [7:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, {idx, 2'b00}, {24'h0, value}, rd);
    if (idx == REG_HEADER) hdr_val = value;
    else trl_val = value;
    apb_xfer(1'b0, {idx, 2'b00}, 32'h0, rd);
    check_field("register readback", {24'h0, value}, rd);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      case (row.op)
        ROW_ITEM: begin
          send_item(row.kind, row.data);
          if (row.typed) begin
            typed_res = pending_results.pop_back();
            typed_res.status = row.status;
            typed_res.popped = row.popped;
            typed_res.fill   = row.fill;
            pending_results.push_back(typed_res);
          end
        end
        ROW_FRAME: send_frame(row.data, 1'b0, row.flag, row.good);
        default:   repeat (row.count) send_item(KIND_WRITE, 8'($urandom));
      endcase
    end

    // random traffic in phases; the block is drained before each register update
    rand_base = items_sent;
    cfg_at    = 0;
    cfg_phase = 0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      if (items_sent - rand_base >= cfg_at) begin
        drain();
        case (cfg_phase)
          0: begin
            set_reg(REG_HEADER, 8'h00);
            set_reg(REG_TRAILER, 8'hFF);
          end
          1: begin
            set_reg(REG_HEADER, 8'hFF);
            set_reg(REG_TRAILER, 8'h00);
          end
          3: begin
            set_reg(REG_HEADER, HEADER_RST);
            set_reg(REG_TRAILER, TRAILER_RST);
          end
          default: begin
            set_reg(REG_HEADER, 8'($urandom));
            set_reg(REG_TRAILER, 8'($urandom));
          end
        endcase
        cfg_phase++;
        cfg_at += CFG_EVERY;
      end
      quiet = (items_sent - rand_base >= RAND_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 9);
      flag_byte = $urandom_range(0, 1) ? LOST_FLAG : 8'($urandom);
      if (pick < 5) begin
        repeat ($urandom_range(0, 3)) send_item(KIND_WRITE, 8'($urandom));
        send_frame(8'h00, 1'b1, flag_byte, 1'b1);
        send_item(KIND_PARSE, 8'($urandom));
      end else if (pick < 7) begin
        send_frame(8'h00, 1'b1, flag_byte, 1'b0);
        send_item(KIND_PARSE, 8'($urandom));
      end else if (pick == 7) begin
        repeat (4) send_item(2'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) send_item(KIND_READ, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 12)) send_item(KIND_WRITE, 8'($urandom));
        send_item(KIND_PARSE, 8'($urandom));
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sbrd_pkg.sv
rtl/sbrd_cfg.sv
rtl/sbrd_datapath.sv
rtl/sbrd_ctrl.sv
rtl/sbus_ring_buffer_deframer.sv
bench/tb_top.sv
